// ===== rtl/core/hmm_pkg.sv =====
// Shared types and constants for the scaled HMM forward step.
`timescale 1ns / 1ps
package hmm_pkg;

  typedef enum logic [1:0] {
    CMD_WR_TRANS = 2'd0,
    CMD_WR_EMIS  = 2'd1,
    CMD_WR_INIT  = 2'd2,
    CMD_OBSERVE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLR,
    ST_MAC,
    ST_MUL,
    ST_SUM,
    ST_SDIV,
    ST_ADIV,
    ST_EMIT,
    ST_AWAIT
  } ctrl_state_e;

  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
  localparam logic [31:0] SCALE_MAX = 32'hFFFF_FFFF;
  // Widths cover up to 64 states: raw up to 2^36, sum up to 2^42
  localparam int unsigned RawW = 37;
  localparam int unsigned SumW = 43;
  localparam int unsigned DivW = RawW + 15;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_table;
    logic acc_clr;
    logic mac_en;
    logic mul_en;
    logic sum_en;
    logic sdiv_start;
    logic adiv_start;
    logic div_step;
    logic alpha_wr;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic sum_zero;
  } dp_stat_t;

endpackage

// ===== rtl/core/hmm_ctrl.sv =====
// Controller state machine for the scaled HMM forward step.
`timescale 1ns / 1ps
module hmm_ctrl #(
  parameter int unsigned NUM_STATES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [1:0]                           in_cmd_i,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  hmm_pkg::dp_stat_t                    stat_i,
  output hmm_pkg::dp_cmd_t                     cmd_o,
  output logic [$clog2(NUM_STATES+1)-1:0]      i_o,
  output logic [$clog2(NUM_STATES+1)-1:0]      j_o
);
  import hmm_pkg::*;
  localparam int unsigned CW = $clog2(NUM_STATES + 1);
  localparam logic [CW-1:0] LastIdx = CW'(NUM_STATES - 1);

  ctrl_state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic outv_q, outv_d;

  assign i_o = i_q;
  assign j_o = j_q;
  assign out_valid_o = outv_q;
  assign in_ready_o = (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      outv_q  <= outv_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    outv_d  = outv_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          i_d = '0;
          j_d = '0;
          if (cmd_e'(in_cmd_i) == CMD_OBSERVE) state_d = ST_CLR;
          else state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_table = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CLR: begin
        cmd_o.acc_clr = 1'b1;
        state_d = ST_MAC;
      end
      // one product per cycle, row i, column j (memory read data arrives in the next cycle)
      ST_MAC: begin
        cmd_o.mac_en = (j_q != '0);
        if (j_q == CW'(NUM_STATES)) begin
          j_d = '0;
          state_d = ST_MUL;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        if (i_q == LastIdx) begin
          i_d = '0;
          state_d = ST_SDIV;
        end else begin
          i_d = i_q + 1'b1;
          state_d = ST_CLR;
        end
      end
      ST_SDIV: begin
        if (j_q == '0) begin
          cmd_o.sdiv_start = 1'b1;
          j_d = CW'(1);
        end else if (stat_i.div_done) begin
          j_d = '0;
          state_d = ST_ADIV;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_ADIV: begin
        if (j_q == '0) begin
          cmd_o.adiv_start = 1'b1;
          j_d = CW'(1);
        end else if (stat_i.div_done) begin
          cmd_o.alpha_wr = 1'b1;
          outv_d = 1'b1;
          j_d = '0;
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          outv_d = 1'b0;
          if (i_q == LastIdx) begin
            i_d = '0;
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + 1'b1;
            state_d = ST_AWAIT;
          end
        end
      end
      // raw value of the new state index is read this cycle
      ST_AWAIT: begin
        state_d = ST_ADIV;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/core/hmm_dp.sv =====
// Datapath for the scaled HMM forward step: tables, MAC, sum and divider.
`timescale 1ns / 1ps
module hmm_dp #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 in_take_i,
  input  logic [1:0]                           in_cmd_i,
  input  logic [5:0]                           in_row_i,
  input  logic [3:0]                           in_col_i,
  input  logic [15:0]                          in_val_i,
  input  logic [5:0]                           in_sym_i,
  input  logic                                 in_first_i,
  input  logic                                 rst_ni,
  input  hmm_pkg::dp_cmd_t                     cmd_i,
  input  logic [$clog2(NUM_STATES+1)-1:0]      i_i,
  input  logic [$clog2(NUM_STATES+1)-1:0]      j_i,
  output hmm_pkg::dp_stat_t                    stat_o,
  output logic [15:0]                          alpha_o,
  output logic [31:0]                          scale_o
);
  import hmm_pkg::*;
  localparam int unsigned SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int unsigned YW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned AW = 15 + 16 + SW + 1;
  localparam int unsigned LW = AW - 15;
  localparam int unsigned DCW = $clog2(DivW + 1);

  // Latched item
  logic [1:0]  cmd_q;
  logic [5:0]  row_q, sym_q;
  logic [3:0]  col_q;
  logic [15:0] val_q;
  logic        first_q;
  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      cmd_q <= in_cmd_i; row_q <= in_row_i; col_q <= in_col_i;
      val_q <= in_val_i; sym_q <= in_sym_i; first_q <= in_first_i;
    end
  end

  // Table memories
  logic [15:0] trans_mem [NUM_STATES*NUM_STATES];
  logic [15:0] emis_mem  [NUM_SYMBOLS*NUM_STATES];
  logic [15:0] init_mem  [NUM_STATES];
  logic [15:0] trans_rd, emis_rd, init_rd, alpha_rd;
  logic [RawW-1:0] raw_mem [NUM_STATES];
  logic [RawW-1:0] raw_rd;

  logic row_ok, col_ok, sym_ok;
  assign col_ok = ({2'b0, col_q} < 6'(NUM_STATES)) || (NUM_STATES > 16);
  assign row_ok = (32'(row_q) < NUM_STATES);
  assign sym_ok = (32'(sym_q) < NUM_SYMBOLS);

  logic [SW-1:0] i_s, j_s;
  assign i_s   = i_i[SW-1:0];
  assign j_s   = j_i[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_table) begin
      if (cmd_e'(cmd_q) == CMD_WR_TRANS && row_ok && col_ok)
        trans_mem[row_q[SW-1:0]*NUM_STATES + 32'(col_q[SW-1:0])] <= val_q;
      if (cmd_e'(cmd_q) == CMD_WR_EMIS && (32'(row_q) < NUM_SYMBOLS) && col_ok)
        emis_mem[row_q[YW-1:0]*NUM_STATES + 32'(col_q[SW-1:0])] <= val_q;
      if (cmd_e'(cmd_q) == CMD_WR_INIT && col_ok)
        init_mem[col_q[SW-1:0]] <= val_q;
    end
    trans_rd <= trans_mem[i_s*NUM_STATES + 32'(j_s)];
    emis_rd  <= emis_mem[sym_q[YW-1:0]*NUM_STATES + 32'(i_s)];
    init_rd  <= init_mem[i_s];
    raw_rd   <= raw_mem[i_s];
  end

  // Alpha vector with valid bits, reset reads as zero
  logic [15:0] alpha_mem [NUM_STATES];
  logic [NUM_STATES-1:0] avld_q;
  logic [15:0] alpha_nxt;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) avld_q <= '0;
    else if (cmd_i.alpha_wr) avld_q[i_s] <= 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.alpha_wr) alpha_mem[i_s] <= alpha_nxt;
    alpha_rd <= avld_q[j_s] ? alpha_mem[j_s] : 16'd0;
  end

  // Multiply-accumulate over one row
  logic [31:0] prod;
  logic [AW-1:0] acc_q;
  assign prod = 32'(trans_rd) * 32'(alpha_rd);
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.mac_en) acc_q <= acc_q + AW'(prod);
  end

  // Raw value for state i; the truncated accumulator may exceed 16 bits
  logic [LW-1:0] acc15;
  logic [LW-1:0] lhs;
  logic [LW+15:0] mul_p;
  logic [RawW-1:0] raw_val;
  assign acc15 = acc_q[AW-1:15];
  assign lhs = first_q ? LW'(init_rd) : acc15;
  assign mul_p = (LW+16)'(lhs) * (LW+16)'(emis_rd);
  assign raw_val = sym_ok ? RawW'(mul_p) : '0;
  logic [RawW-1:0] raw_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) raw_q <= raw_val;
    if (cmd_i.sum_en) raw_mem[i_s] <= raw_q;
  end

  // Exact sum of the raw vector
  logic [SumW-1:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr && i_i == '0) sum_q <= '0;
    else if (cmd_i.sum_en) sum_q <= sum_q + SumW'(raw_q);
  end
  assign stat_o.sum_zero = (sum_q == '0);

  // Shared restoring divider, one quotient bit a cycle
  logic [DivW-1:0] num_q, q_q;
  logic [SumW:0]   rem_q;
  logic [DCW-1:0]  cnt_q;
  logic [SumW:0]   trial;
  logic [SumW:0]   shifted;
  assign shifted = {rem_q[SumW-1:0], num_q[DivW-1]};
  assign trial = shifted - {1'b0, sum_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.sdiv_start || cmd_i.adiv_start) cnt_q <= DCW'(DivW);
    else if (cmd_i.div_step && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sdiv_start) begin
      num_q <= DivW'(1) << 46; rem_q <= '0; q_q <= '0;
    end else if (cmd_i.adiv_start) begin
      num_q <= DivW'(raw_rd) << 15; rem_q <= '0; q_q <= '0;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      num_q <= num_q << 1;
      if (!trial[SumW]) begin
        rem_q <= trial; q_q <= {q_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted; q_q <= {q_q[DivW-2:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = (cnt_q == '0);

  // Normalized alpha, zero when the sum is zero
  assign alpha_nxt = stat_o.sum_zero ? 16'd0 : q_q[15:0];

  // Scale factor register
  logic [31:0] scale_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.adiv_start && i_i == '0) begin
      if (stat_o.sum_zero) scale_q <= SCALE_ONE;
      else if (q_q[DivW-1:32] != '0) scale_q <= SCALE_MAX;
      else scale_q <= q_q[31:0];
    end
  end
  assign scale_o = scale_q;

  // Alpha output register
  logic [15:0] a_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.alpha_wr) a_q <= alpha_nxt;
  end
  assign alpha_o = a_q;
endmodule

// ===== rtl/core/hmm_scaled_forward_step.sv =====
// Top level of the scaled HMM forward step.
// Table writes go through a write state and back to idle. An observation
// runs one multiply-accumulate per cycle over the transition memory port,
// then one 52-bit restoring division for the scale and one per state for
// alpha; a result the receiver stalls holds the block until it is taken.
// Results go out one per state; the block takes the next item after the last.
`timescale 1ns / 1ps
module hmm_scaled_forward_step #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], row_index[7:2], col_index[11:8], table_value[27:12],
  // symbol[33:28], first_of_sequence[34], zero[39:35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // state_index[3:0], alpha_value[19:4], scale_factor[51:20], zero[55:52]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import hmm_pkg::*;
  localparam int unsigned CW = $clog2(NUM_STATES + 1);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic [CW-1:0] ci, cj, ei_q;
  logic [15:0] alpha;
  logic [31:0] scale;
  logic take;
  assign take = s_axis_tvalid && s_axis_tready;

  hmm_ctrl #(.NUM_STATES(NUM_STATES)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_cmd_i(s_axis_tdata[1:0]),
    .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(dstat), .cmd_o(dcmd), .i_o(ci), .j_o(cj)
  );

  hmm_dp #(.NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
    .clk_i, .rst_ni, .in_take_i(take),
    .in_cmd_i(s_axis_tdata[1:0]), .in_row_i(s_axis_tdata[7:2]),
    .in_col_i(s_axis_tdata[11:8]), .in_val_i(s_axis_tdata[27:12]),
    .in_sym_i(s_axis_tdata[33:28]), .in_first_i(s_axis_tdata[34]),
    .cmd_i(dcmd), .i_i(ci), .j_i(cj), .stat_o(dstat),
    .alpha_o(alpha), .scale_o(scale)
  );

  // State index of the result on the port
  always_ff @(posedge clk_i) begin
    if (dcmd.alpha_wr) ei_q <= ci;
  end

  assign m_axis_tdata = {4'b0, scale, alpha, 4'(ei_q)};
  assign m_axis_tlast = (ei_q == CW'(NUM_STATES - 1));
endmodule

// ===== rtl/core/hmm_checker.sv =====
// Port checker for the scaled HMM forward step, bound to the top level.
`timescale 1ns / 1ps
module hmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // No new item is taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))
    else $error("result changed under stall");

  // Zero scale never appears
  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[51:20] != 32'd0) else $error("zero scale");

  // Alpha never exceeds one
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:4] <= 16'h8000) else $error("alpha above one");
endmodule

bind hmm_scaled_forward_step hmm_checker u_hmm_checker (.*);
